// ===== rtl/ttd_pkg.sv =====
`timescale 1ns / 1ps

package ttd_pkg;

    // Field widths.
    localparam int POS_WIDTH   = 24;
    localparam int HEAD_W      = 16;
    localparam int RELH_W      = HEAD_W + 1;
    localparam int MAG_W       = 2 * POS_WIDTH;
    localparam int DIST_W      = 23;
    localparam int SPEED_W     = 16;
    localparam int BRAKE_W     = 11;
    localparam int CODE_W      = 2;

    localparam int SAMPLE_RATE_HZ = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIST_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEADING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DISTANCE = 2'd1;

    // Job queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Motion commands.
    localparam logic [CODE_W-1:0] MOTION_STOP  = 2'd0;
    localparam logic [CODE_W-1:0] MOTION_LEFT  = 2'd1;
    localparam logic [CODE_W-1:0] MOTION_RIGHT = 2'd2;
    localparam logic [CODE_W-1:0] MOTION_FWD   = 2'd3;

    // Reported phase codes.
    localparam logic [CODE_W-1:0] PHASE_TURNING  = 2'd0;
    localparam logic [CODE_W-1:0] PHASE_DRIVING  = 2'd1;
    localparam logic [CODE_W-1:0] PHASE_FINISHED = 2'd2;

    // Braking polynomial scaled by 2^16, speed in Q8.8, result in 1/1024 m.
    localparam int POLY_W = 27;
    localparam logic [POLY_W-1:0]  BRAKE_A     = 27'd1788;
    localparam logic [POLY_W-1:0]  BRAKE_B     = 27'd33633;
    localparam logic [POLY_W-1:0]  BRAKE_C_RND = 27'd1422708 + 27'd32768;
    localparam logic [SPEED_W-1:0] SPEED_KNEE  = 16'd192;
    localparam logic [BRAKE_W-1:0] BRAKE_FAR   = 11'd1178;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic signed [HEAD_W-1:0]    heading_z;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]  motion;
        logic [CODE_W-1:0]  phase;
        logic [SPEED_W-1:0] speed;
        logic [BRAKE_W-1:0] braking_distance;
    } t_out_item;

    // Work handed from front to back: step since the last sample, new relative
    // position and relative heading.
    typedef struct packed {
        logic signed [POS_WIDTH-1:0] dx;
        logic signed [POS_WIDTH-1:0] dy;
        logic signed [POS_WIDTH-1:0] px;
        logic signed [POS_WIDTH-1:0] py;
        logic signed [RELH_W-1:0]    rel_h;
    } t_job;

    function automatic logic [POS_WIDTH-1:0] f_abs(input logic signed [POS_WIDTH-1:0] v);
        f_abs = v[POS_WIDTH-1] ? POS_WIDTH'(-v) : POS_WIDTH'(v);
    endfunction

endpackage

// ===== rtl/ttd_front.sv =====
`timescale 1ns / 1ps

module ttd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ttd_pkg::t_in_item i_item,
    output ttd_pkg::t_job     o_job
);

    logic                                  r_taken;
    logic signed [ttd_pkg::POS_WIDTH-1:0]  r_org_x;
    logic signed [ttd_pkg::POS_WIDTH-1:0]  r_org_y;
    logic signed [ttd_pkg::HEAD_W-1:0]     r_org_h;
    logic signed [ttd_pkg::POS_WIDTH-1:0]  r_prev_x;
    logic signed [ttd_pkg::POS_WIDTH-1:0]  r_prev_y;

    logic signed [ttd_pkg::POS_WIDTH-1:0]  rx;
    logic signed [ttd_pkg::POS_WIDTH-1:0]  ry;

    // Relative positions wrap to the position width.
    assign rx = i_item.pos_x - r_org_x;
    assign ry = i_item.pos_y - r_org_y;

    always_comb begin
        if (!r_taken) begin
            // The origin sample has no motion and no heading offset.
            o_job.dx    = '0;
            o_job.dy    = '0;
            o_job.px    = r_prev_x;
            o_job.py    = r_prev_y;
            o_job.rel_h = '0;
        end else begin
            o_job.dx    = rx - r_prev_x;
            o_job.dy    = ry - r_prev_y;
            o_job.px    = rx;
            o_job.py    = ry;
            o_job.rel_h = {i_item.heading_z[ttd_pkg::HEAD_W-1], i_item.heading_z}
                        - {r_org_h[ttd_pkg::HEAD_W-1], r_org_h};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken  <= 1'b0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_org_h  <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (i_push) begin
            if (!r_taken) begin
                r_taken <= 1'b1;
                r_org_x <= i_item.pos_x;
                r_org_y <= i_item.pos_y;
                r_org_h <= i_item.heading_z;
            end else begin
                r_prev_x <= rx;
                r_prev_y <= ry;
            end
        end
    end

endmodule

// ===== rtl/ttd_queue.sv =====
`timescale 1ns / 1ps

module ttd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttd_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output ttd_pkg::t_job o_job
);

    ttd_pkg::t_job                 r_mem [ttd_pkg::QDEPTH];
    logic [ttd_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [ttd_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [ttd_pkg::QPTR_W:0]      r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (ttd_pkg::QPTR_W + 1)'(ttd_pkg::QDEPTH));
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ttd_back.sv =====
`timescale 1ns / 1ps

module ttd_back #(
    parameter int SAMPLE_RATE_HZ = ttd_pkg::SAMPLE_RATE_HZ
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  ttd_pkg::t_job                      i_job,
    output logic                               o_pop,
    input  logic signed [ttd_pkg::HEAD_W-1:0]  i_target_heading,
    input  logic [ttd_pkg::DIST_W-1:0]         i_target_distance,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ttd_pkg::t_out_item                 o_out_data
);

    localparam int SR_W    = $clog2(SAMPLE_RATE_HZ + 1);
    localparam int SCALE_W = ttd_pkg::POS_WIDTH + SR_W;
    localparam int MAG_W   = ttd_pkg::MAG_W;
    localparam int DEC_W   = ttd_pkg::POS_WIDTH + 2;
    localparam int TRN_W   = ttd_pkg::RELH_W + 1;
    localparam logic [MAG_W-1:0] ROOT_START = MAG_W'(1) << (MAG_W - 2);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SQA    = 8'b0000_0010,
        S_SQB    = 8'b0000_0100,
        S_ROOT   = 8'b0000_1000,
        S_SCALE  = 8'b0001_0000,
        S_BSQ    = 8'b0010_0000,
        S_BRAKE  = 8'b0100_0000,
        S_DECIDE = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        PH_TURN  = 3'b001,
        PH_DRIVE = 3'b010,
        PH_DONE  = 3'b100
    } t_phase;

    t_state                             r_state, n_state;
    t_phase                             r_phase, n_phase;
    ttd_pkg::t_job                      r_job, n_job;
    logic                               r_pass, n_pass;
    logic [MAG_W-1:0]                   r_acc, n_acc;
    logic [MAG_W-1:0]                   r_n, n_n;
    logic [MAG_W-1:0]                   r_root, n_root;
    logic [MAG_W-1:0]                   r_bit, n_bit;
    logic [ttd_pkg::SPEED_W-1:0]        r_speed, n_speed;
    logic [ttd_pkg::POS_WIDTH-1:0]      r_range, n_range;
    logic [ttd_pkg::SPEED_W-1:0]        r_sq, n_sq;
    logic [ttd_pkg::BRAKE_W-1:0]        r_brake, n_brake;
    logic                               r_out_valid, n_out_valid;
    ttd_pkg::t_out_item                 r_out, n_out;

    logic [ttd_pkg::POS_WIDTH-1:0]      op_a, op_b, op_sel;
    logic [MAG_W-1:0]                   sq;
    logic [MAG_W-1:0]                   trial;
    logic [SCALE_W-1:0]                 scaled;
    logic [7:0]                         s8;
    logic [ttd_pkg::POLY_W-1:0]         poly;
    logic signed [DEC_W-1:0]            margin;
    logic signed [TRN_W-1:0]            th_ext, rh_ext, turn_left;
    logic                               out_free;

    // First pass measures the step since the last sample, second the range.
    assign op_a   = r_pass ? ttd_pkg::f_abs(r_job.px) : ttd_pkg::f_abs(r_job.dx);
    assign op_b   = r_pass ? ttd_pkg::f_abs(r_job.py) : ttd_pkg::f_abs(r_job.dy);
    assign op_sel = (r_state == S_SQA) ? op_a : op_b;
    assign sq     = op_sel * op_sel;
    assign trial  = r_root + r_bit;
    assign scaled = r_root[ttd_pkg::POS_WIDTH-1:0] * SR_W'(SAMPLE_RATE_HZ);
    assign s8     = r_speed[7:0];
    assign poly   = ttd_pkg::BRAKE_A * ttd_pkg::POLY_W'(r_sq)
                  + ttd_pkg::BRAKE_B * ttd_pkg::POLY_W'(s8)
                  + ttd_pkg::BRAKE_C_RND;
    assign margin = $signed({3'b000, i_target_distance}) - $signed({2'b00, r_range})
                  - $signed({(DEC_W - ttd_pkg::BRAKE_W)'(0), r_brake});
    assign th_ext    = TRN_W'(i_target_heading);
    assign rh_ext    = TRN_W'(r_job.rel_h);
    assign turn_left = -th_ext;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_pop       = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_job       = r_job;
        n_pass      = r_pass;
        n_acc       = r_acc;
        n_n         = r_n;
        n_root      = r_root;
        n_bit       = r_bit;
        n_speed     = r_speed;
        n_range     = r_range;
        n_sq        = r_sq;
        n_brake     = r_brake;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_pass  = 1'b0;
                    n_state = S_SQA;
                end
            end
            S_SQA: begin
                n_acc   = sq;
                n_state = S_SQB;
            end
            S_SQB: begin
                n_n     = r_acc + sq;
                n_root  = '0;
                n_bit   = ROOT_START;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                // One result bit per cycle.
                if (r_n >= trial) begin
                    n_n    = r_n - trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = r_pass ? S_BSQ : S_SCALE;
                end
            end
            S_SCALE: begin
                if (scaled[SCALE_W-1:ttd_pkg::SPEED_W+2] != '0) begin
                    n_speed = '1;
                end else begin
                    n_speed = scaled[ttd_pkg::SPEED_W+1:2];
                end
                n_pass  = 1'b1;
                n_state = S_SQA;
            end
            S_BSQ: begin
                n_range = r_root[ttd_pkg::POS_WIDTH-1:0];
                n_sq    = s8 * s8;
                n_state = S_BRAKE;
            end
            S_BRAKE: begin
                if (r_speed > ttd_pkg::SPEED_KNEE) begin
                    n_brake = ttd_pkg::BRAKE_FAR;
                end else begin
                    n_brake = poly[ttd_pkg::POLY_W-1:16];
                end
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_out.speed            = r_speed;
                    n_out.braking_distance = r_brake;
                    n_out.motion           = ttd_pkg::MOTION_STOP;
                    case (r_phase)
                        PH_TURN: begin
                            if (i_target_heading < 0) begin
                                if (turn_left - rh_ext >= 0) begin
                                    n_out.motion = ttd_pkg::MOTION_LEFT;
                                end else begin
                                    n_phase = PH_DRIVE;
                                end
                            end else begin
                                if (th_ext + rh_ext >= 0) begin
                                    n_out.motion = ttd_pkg::MOTION_RIGHT;
                                end else begin
                                    n_phase = PH_DRIVE;
                                end
                            end
                        end
                        PH_DRIVE: begin
                            if (margin >= 0) begin
                                n_out.motion = ttd_pkg::MOTION_FWD;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                            n_phase = PH_DONE;
                        end
                    endcase
                    case (n_phase)
                        PH_TURN:  n_out.phase = ttd_pkg::PHASE_TURNING;
                        PH_DRIVE: n_out.phase = ttd_pkg::PHASE_DRIVING;
                        default:  n_out.phase = ttd_pkg::PHASE_FINISHED;
                    endcase
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_TURN;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_pass      <= n_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_acc   <= n_acc;
        r_n     <= n_n;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_speed <= n_speed;
        r_range <= n_range;
        r_sq    <= n_sq;
        r_brake <= n_brake;
        r_out   <= n_out;
    end

endmodule

// ===== rtl/turn_then_drive_braking_controller.sv =====
`timescale 1ns / 1ps
// The back end handles one sample at a time and sets the throughput: it runs the shared
// squarer and the one-bit-per-cycle square root twice per sample (24 steps each), and
// holds its result in its last state while the output is stalled.
// The front takes samples into a four-entry queue while the back end is busy.
// Reset is synchronous and active low; it clears origin, phase, queue and targets.

module turn_then_drive_braking_controller #(
    parameter int SAMPLE_RATE_HZ = ttd_pkg::SAMPLE_RATE_HZ
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ttd_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ttd_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic signed [ttd_pkg::HEAD_W-1:0]  r_target_heading;
    logic [ttd_pkg::DIST_W-1:0]         r_target_distance;

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    ttd_pkg::t_job  front_job;
    ttd_pkg::t_job  q_job;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_heading  <= '0;
            r_target_distance <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ttd_pkg::CFG_TARGET_HEADING:
                    r_target_heading <= i_cfg_data[ttd_pkg::HEAD_W-1:0];
                ttd_pkg::CFG_TARGET_DISTANCE:
                    r_target_distance <= i_cfg_data[ttd_pkg::DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ttd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_data),
        .o_job   (front_job)
    );

    ttd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    ttd_back #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (q_valid),
        .i_job             (q_job),
        .o_pop             (pop),
        .i_target_heading  (r_target_heading),
        .i_target_distance (r_target_distance),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_data        (o_out_data)
    );

endmodule

// ===== tb/braking_command_checker.sv =====
`timescale 1ns / 1ps

module braking_command_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  ttd_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  ttd_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_failures,
    output int                             o_pending
);
    import ttd_pkg::*;

    localparam longint RATE_HZ    = 10;
    localparam longint SPEED_MAX  = 65535;
    localparam longint KNEE_SPEED = 192;
    localparam longint BRAKE_HIGH = 1178;
    localparam longint QUAD_COEF  = 1788;
    localparam longint LIN_COEF   = 33633;
    localparam longint CONST_TERM = 1422708;
    localparam longint HALF_LSB   = 32768;

    longint     org_x, org_y, org_h;
    longint     last_rx, last_ry;
    bit         have_origin;
    logic [1:0] phase_now;
    longint     tgt_heading, tgt_distance;
    int         failures;
    t_out_item  expected_cmds[$];
    t_out_item  want;

    function automatic longint wrap_pos(input longint v);
        logic signed [POS_WIDTH-1:0] w;
        w = v[POS_WIDTH-1:0];
        return longint'(w);
    endfunction

    // Largest root whose square does not exceed n, one bit at a time.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) root = trial;
        end
        return root;
    endfunction

    function automatic t_out_item predict_command(input t_in_item s);
        longint          x, y, h, rx, ry, dx, dy, rel_h, range_q10, brake;
        longint unsigned spd;
        bit              go;
        t_out_item       r;
        x = longint'($signed(s.pos_x));
        y = longint'($signed(s.pos_y));
        h = longint'($signed(s.heading_z));
        spd = 0;
        if (!have_origin) begin
            org_x = x;
            org_y = y;
            org_h = h;
            have_origin = 1'b1;
        end else begin
            rx = wrap_pos(x - org_x);
            ry = wrap_pos(y - org_y);
            dx = wrap_pos(rx - last_rx);
            dy = wrap_pos(ry - last_ry);
            spd = int_sqrt(dx * dx + dy * dy) * RATE_HZ / 4;
            if (spd > SPEED_MAX) spd = SPEED_MAX;
            last_rx = rx;
            last_ry = ry;
        end
        rel_h = h - org_h;
        range_q10 = longint'(int_sqrt(last_rx * last_rx + last_ry * last_ry));
        if (spd > KNEE_SPEED) begin
            brake = BRAKE_HIGH;
        end else begin
            brake = longint'((QUAD_COEF * spd * spd + LIN_COEF * spd + CONST_TERM
                              + HALF_LSB) >> 16);
        end
        r.motion = MOTION_STOP;
        case (phase_now)
            PHASE_TURNING: begin
                if (tgt_heading < 0) go = (-tgt_heading - rel_h) >= 0;
                else go = (tgt_heading + rel_h) >= 0;
                if (go) r.motion = (tgt_heading < 0) ? MOTION_LEFT : MOTION_RIGHT;
                else phase_now = PHASE_DRIVING;
            end
            PHASE_DRIVING: begin
                if (tgt_distance - range_q10 - brake >= 0) r.motion = MOTION_FWD;
                else phase_now = PHASE_FINISHED;
            end
            default: begin
                phase_now = PHASE_FINISHED;
            end
        endcase
        r.phase = phase_now;
        r.speed = spd[SPEED_W-1:0];
        r.braking_distance = brake[BRAKE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            org_x = 0;
            org_y = 0;
            org_h = 0;
            last_rx = 0;
            last_ry = 0;
            have_origin = 1'b0;
            phase_now = PHASE_TURNING;
            tgt_heading = 0;
            tgt_distance = 0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TARGET_HEADING)
                    tgt_heading = longint'($signed(i_cfg_data[HEAD_W-1:0]));
                else if (i_cfg_index == CFG_TARGET_DISTANCE)
                    tgt_distance = longint'(i_cfg_data);
            end
            if (i_in_valid && !i_in_stall)
                expected_cmds.push_back(predict_command(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: command with none pending: motion %0d phase %0d",
                                 $time, i_out_data.motion, i_out_data.phase);
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_out_data.motion !== want.motion || i_out_data.phase !== want.phase
                        || i_out_data.speed !== want.speed
                        || i_out_data.braking_distance !== want.braking_distance) begin
                        failures++;
                        if (failures <= 10) begin
                            $write("%0t: expected motion %0d phase %0d speed %0d brake %0d,",
                                   $time, want.motion, want.phase, want.speed,
                                   want.braking_distance);
                            $display(" got motion %0d phase %0d speed %0d brake %0d",
                                     i_out_data.motion, i_out_data.phase, i_out_data.speed,
                                     i_out_data.braking_distance);
                        end
                    end
                end
            end
        end
        o_failures <= failures;
        o_pending <= expected_cmds.size();
    end

endmodule

// ===== tb/turn_then_drive_braking_controller_tb.sv =====
`timescale 1ns / 1ps

module turn_then_drive_braking_controller_tb;
    import ttd_pkg::*;

    localparam longint ORIGIN_X   = -8388608;
    localparam longint ORIGIN_Y   = 8388607;
    localparam longint ORIGIN_H   = -32768;
    localparam longint DRIVE_SPAN = 4194303;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    int                    failures;
    int                    pending;

    int          burst_left = 0;
    longint      cur_rx = 0;
    longint      cur_ry = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int unsigned beat = 0;

    turn_then_drive_braking_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    braking_command_checker cmd_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge i_clk) begin
        beat <= beat + 1;
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(40, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= beat[2];
        endcase
    end

    task automatic send_sample(input longint x, input longint y, input longint h);
        t_in_item s;
        int       gap;
        s.pos_x = x[POS_WIDTH-1:0];
        s.pos_y = y[POS_WIDTH-1:0];
        s.heading_z = h[HEAD_W-1:0];
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_rel(input longint rx, input longint ry, input longint h);
        cur_rx = rx;
        cur_ry = ry;
        send_sample(ORIGIN_X + rx, ORIGIN_Y + ry, h);
    endtask

    // Short steps around the current relative position with an occasional jump,
    // so speeds cover both sides of the braking knee.
    task automatic walk(input int n, input longint span, input int h_lo, input int h_hi);
        longint nx, ny;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                nx = cur_rx + 77 + longint'($urandom_range(0, 1));
                ny = cur_ry;
            end else if ($urandom_range(0, 3) != 0) begin
                nx = cur_rx + longint'($urandom_range(0, 160)) - 80;
                ny = cur_ry + longint'($urandom_range(0, 160)) - 80;
            end else begin
                nx = longint'($urandom_range(0, 32'(2 * span))) - span;
                ny = longint'($urandom_range(0, 32'(2 * span))) - span;
            end
            if (nx > span || nx < -span) nx = 0;
            if (ny > span || ny < -span) ny = 0;
            send_rel(nx, ny, h_lo + longint'($urandom_range(0, h_hi - h_lo)));
        end
    endtask

    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++)
            send_sample(longint'($urandom()), longint'($urandom()), longint'($urandom()));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Heading register value with random bits above the 16-bit field.
    function automatic logic [CFG_DATA_W-1:0] heading_word(input int h);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        w[HEAD_W-1:0] = h[HEAD_W-1:0];
        return w;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset value: zero heading spins right. The origin heading is the
        // most negative one, so the relative heading reaches past 16 bits.
        send_rel(0, 0, ORIGIN_H);
        send_sample(8388607, -8388608, 32767);
        send_sample(0, 0, 0);
        send_sample(5592405, -5592406, 21845);
        send_sample(5592405, -5592406, -21846);
        send_rel(100, -100, 1);
        send_rel(177, -100, -1);
        send_rel(255, -100, 0);
        send_rel(255, -99, 100);
        send_rel(8388607, -8388608, 12345);
        send_rel(-8388608, 8388607, -12345);

        drain();
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom()));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
        write_reg(CFG_TARGET_HEADING, heading_word(32767));
        write_reg(CFG_TARGET_DISTANCE, '0);
        send_noise(90);

        drain();
        write_reg(CFG_TARGET_HEADING, heading_word($urandom_range(0, 32767)));
        send_noise(80);

        // Spin left until the relative heading passes the target; the first
        // sample sits exactly on the limit.
        drain();
        write_reg(CFG_TARGET_HEADING, heading_word(-32768));
        send_rel(0, 0, 0);
        walk(70, 4096, -32768, 0);
        send_rel(cur_rx, cur_ry, 1);

        drain();
        write_reg(CFG_TARGET_DISTANCE, CFG_DATA_W'(8388607));
        walk(240, DRIVE_SPAN, -32768, 32767);
        drain();
        write_reg(CFG_TARGET_HEADING, heading_word(0));
        walk(20, DRIVE_SPAN, -32768, 32767);
        send_rel(3000, 4000, 0);

        // Range 5000 and braking 22 leave zero margin; one more step ends driving.
        drain();
        write_reg(CFG_TARGET_DISTANCE, CFG_DATA_W'(5022));
        send_rel(3000, 4000, 0);
        send_rel(3001, 4000, 0);

        drain();
        write_reg(CFG_TARGET_DISTANCE, '0);
        write_reg(CFG_TARGET_HEADING, heading_word($urandom_range(0, 65535)));
        send_noise(60);

        drain();
        repeat (70) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
